>>> rtl/core/cdf24wl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CDF 2/4 lifting wavelet core.
package cdf24wl_pkg;

  localparam int MAX_LINE = 64;
  localparam int HALF_MAX = MAX_LINE / 2;
  localparam int HALF_MIN = 2;
  localparam int ADDR_W = $clog2(MAX_LINE);
  localparam int HALF_W = $clog2(HALF_MAX + 1);
  localparam int LEN_W = ADDR_W + 1;

  localparam int IN_W = 18;
  localparam int OUT_W = 20;
  localparam int PAIR_W = 6;
  localparam int SUM_W = OUT_W + 1;
  localparam int PROD_W = SUM_W + 6;

  localparam int UPD_NEAR = 19;
  localparam int UPD_FAR = 3;
  localparam int UPD_SHIFT = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int DRAIN_LEN = 3;
  localparam int DRAIN_W = $clog2(DRAIN_LEN);

  localparam int REG_IDX_W = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIRECTION  = 1'b0,
    REG_PAIR_COUNT = 1'b1
  } reg_index_t;

  typedef logic signed [IN_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0] word_t;

  typedef struct packed {
    sample_t             value;
    logic [ADDR_W-1:0]   addr;
    logic                complete;
    logic                dir;
    logic [HALF_W-1:0]   half;
  } line_cmd_t;

endpackage

>>> rtl/core/cdf24wl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cdf24wl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/cdf24wl_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance and line position tracking.
module cdf24wl_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  cdf24wl_pkg::sample_t                 in_value,
  input  logic                                 wr_en,
  input  logic [cdf24wl_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [cdf24wl_pkg::PAIR_W-1:0]       wr_data,
  input  logic                                 queue_full,
  output logic                                 busy,
  output logic                                 push,
  output cdf24wl_pkg::line_cmd_t               cmd
);
  import cdf24wl_pkg::*;

  logic                direction;
  logic [PAIR_W-1:0]   pair_count;
  logic [ADDR_W-1:0]   load_count;
  logic [HALF_W-1:0]   half;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    count_next;
  logic                complete;

  always_comb begin
    if (pair_count < PAIR_W'(HALF_MIN)) begin
      half = HALF_W'(HALF_MIN);
    end else if (pair_count > PAIR_W'(HALF_MAX)) begin
      half = HALF_W'(HALF_MAX);
    end else begin
      half = HALF_W'(pair_count);
    end
  end

  assign len        = LEN_W'(half) << 1;
  assign count_next = LEN_W'(load_count) + LEN_W'(1);
  assign complete   = count_next >= len;

  assign busy = queue_full;
  assign push = start && !queue_full;

  always_comb begin
    cmd.value    = in_value;
    cmd.addr     = load_count;
    cmd.complete = complete;
    cmd.dir      = direction;
    cmd.half     = half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      pair_count <= PAIR_W'(HALF_MAX);
      load_count <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_DIRECTION:  direction <= wr_data[0];
          REG_PAIR_COUNT: pair_count <= wr_data;
          default: ;
        endcase
      end
      if (push) begin
        load_count <= complete ? '0 : count_next[ADDR_W-1:0];
      end
    end
  end

endmodule

>>> rtl/core/cdf24wl_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the transform engine.
module cdf24wl_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  cdf24wl_pkg::line_cmd_t  push_cmd,
  output logic                    full,
  input  logic                    pop,
  output logic                    valid,
  output cdf24wl_pkg::line_cmd_t  head
);
  import cdf24wl_pkg::*;

  line_cmd_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/cdf24wl_back.sv
`timescale 1ns / 1ps
// Transform engine: line and result buffers, predict and update passes, result output.
module cdf24wl_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  cdf24wl_pkg::line_cmd_t  q_head,
  output logic                    q_pop,
  output logic                    valid,
  output cdf24wl_pkg::word_t      out_value,
  output logic                    last
);
  import cdf24wl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_UPD,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t              state;
  state_t              a_state;
  logic [HALF_W-1:0]   j;
  logic [HALF_W-1:0]   j_inc;
  logic [HALF_W-1:0]   j_dec;
  logic [HALF_W-1:0]   last_j;
  logic                ph;
  logic                pass_no;
  logic                dir;
  logic [HALF_W-1:0]   half;
  logic [DRAIN_W-1:0]  drain_cnt;
  logic                pass_active;

  logic                a_valid;
  logic [HALF_W-1:0]   a_j;
  logic [HALF_W-1:0]   a_j_dec;
  logic                a_ph;
  logic                a_last;
  logic                a_pred_last;
  logic                u_valid;

  logic                line_we;
  logic [ADDR_W-1:0]   line_waddr;
  logic [IN_W-1:0]     line_wdata;
  logic [ADDR_W-1:0]   line_raddr;
  logic [IN_W-1:0]     line_rdata;
  logic                res_we;
  logic [ADDR_W-1:0]   res_waddr;
  logic [OUT_W-1:0]    res_wdata;
  logic [ADDR_W-1:0]   res_raddr;
  logic [OUT_W-1:0]    res_rdata;

  word_t               line_word;
  word_t               res_word;
  word_t               h_in;
  word_t               e_prev;
  word_t               o_reg;
  word_t               win [4];

  logic [HALF_W-1:0]         u_i;
  sample_t                   u_e;
  word_t                     u_h0;
  logic signed [SUM_W-1:0]   u_s;
  logic signed [PROD_W-1:0]  u_p;

  logic signed [SUM_W-1:0]   near_sum;
  logic signed [SUM_W-1:0]   far_sum;
  logic signed [PROD_W-1:0]  upd_prod;
  logic signed [PROD_W-1:0]  h0_ext;
  logic signed [PROD_W-1:0]  s_ext;
  logic signed [PROD_W-1:0]  e_ext;
  logic signed [PROD_W-1:0]  a_term;
  logic signed [PROD_W-1:0]  upd_val;

  logic signed [SUM_W-1:0]   fp_sum;
  logic signed [SUM_W-1:0]   fp_mid;
  logic signed [SUM_W-1:0]   fp_end;
  logic signed [SUM_W-1:0]   ip_sum;
  logic signed [SUM_W-1:0]   ip_odd;

  cdf24wl_ram #(
    .WIDTH (IN_W),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  cdf24wl_ram #(
    .WIDTH (OUT_W),
    .DEPTH (MAX_LINE)
  ) u_result_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign line_we    = q_pop;
  assign line_waddr = q_head.addr;
  assign line_wdata = q_head.value;

  assign pass_active = (state == S_PRED) || (state == S_UPD) || (state == S_EMIT);
  assign last_j      = (state == S_UPD) ? half : half - HALF_W'(1);
  assign j_inc       = j + HALF_W'(1);
  assign j_dec       = j - HALF_W'(1);
  assign a_j_dec     = a_j - HALF_W'(1);
  assign a_pred_last = a_j == half - HALF_W'(1);

  assign line_word = OUT_W'($signed(line_rdata));
  assign res_word  = $signed(res_rdata);
  assign h_in      = dir ? line_word : res_word;

  always_comb begin
    line_raddr = ADDR_W'(half) + ADDR_W'(j);
    res_raddr  = {j[ADDR_W-2:0], ph};
    case (state)
      S_PRED: begin
        if (!dir) begin
          line_raddr = {j[ADDR_W-2:0], ph};
        end
        res_raddr = ph ? {j_inc[ADDR_W-2:0], 1'b0} : {j[ADDR_W-2:0], 1'b0};
      end
      S_UPD: begin
        if (ph) begin
          line_raddr = dir ? ADDR_W'(j_dec) : {j_dec[ADDR_W-2:0], 1'b0};
        end
        res_raddr = ADDR_W'(half) + ADDR_W'(j);
      end
      default: ;
    endcase
  end

  // Update filter, first stage: tap sums and the weighted difference.
  assign near_sum = SUM_W'(win[1]) + SUM_W'(win[2]);
  assign far_sum  = SUM_W'(win[0]) + SUM_W'(win[3]);
  assign upd_prod = PROD_W'(near_sum) * PROD_W'(UPD_NEAR)
                  - PROD_W'(far_sum) * PROD_W'(UPD_FAR);

  // Update filter, second stage: boundary selection and the lifting add.
  assign h0_ext = PROD_W'(u_h0);
  assign s_ext  = PROD_W'(u_s);
  assign e_ext  = PROD_W'(u_e);

  always_comb begin
    if (u_i == '0) begin
      a_term = h0_ext >>> 1;
    end else if ((u_i == HALF_W'(1)) || (u_i == half - HALF_W'(1))) begin
      a_term = s_ext >>> 2;
    end else begin
      a_term = u_p >>> UPD_SHIFT;
    end
  end

  assign upd_val = dir ? (e_ext - a_term) : (e_ext + a_term);

  assign fp_sum = SUM_W'(e_prev) + SUM_W'(line_word);
  assign fp_mid = SUM_W'(o_reg) - (fp_sum >>> 1);
  assign fp_end = SUM_W'(line_word) - SUM_W'(e_prev);
  assign ip_sum = SUM_W'(e_prev) + SUM_W'(res_word);
  assign ip_odd = SUM_W'(line_word) + (a_pred_last ? SUM_W'(e_prev) : (ip_sum >>> 1));

  always_comb begin
    res_we    = 1'b0;
    res_waddr = ADDR_W'(half) + ADDR_W'(a_j);
    res_wdata = upd_val[OUT_W-1:0];
    if (u_valid) begin
      res_we    = 1'b1;
      res_waddr = dir ? {u_i[ADDR_W-2:0], 1'b0} : ADDR_W'(u_i);
      res_wdata = upd_val[OUT_W-1:0];
    end else if (a_valid && (a_state == S_PRED)) begin
      if (dir) begin
        res_we    = a_ph;
        res_waddr = {a_j[ADDR_W-2:0], 1'b1};
        res_wdata = ip_odd[OUT_W-1:0];
      end else if (!a_ph) begin
        res_we    = a_j != '0;
        res_waddr = ADDR_W'(half) + ADDR_W'(a_j_dec);
        res_wdata = fp_mid[OUT_W-1:0];
      end else begin
        res_we    = a_pred_last;
        res_waddr = ADDR_W'(half) + ADDR_W'(a_j);
        res_wdata = fp_end[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      ph        <= 1'b0;
      pass_no   <= 1'b0;
      dir       <= 1'b0;
      half      <= HALF_W'(HALF_MAX);
      drain_cnt <= '0;
      a_valid   <= 1'b0;
      a_state   <= S_IDLE;
      a_j       <= '0;
      a_ph      <= 1'b0;
      a_last    <= 1'b0;
      u_valid   <= 1'b0;
      valid     <= 1'b0;
      last      <= 1'b0;
      out_value <= '0;
    end else begin
      a_valid   <= pass_active;
      a_state   <= state;
      a_j       <= j;
      a_ph      <= ph;
      a_last    <= ph && (j == half - HALF_W'(1));
      u_valid   <= a_valid && (a_state == S_UPD) && a_ph && (a_j != '0);
      valid     <= a_valid && (a_state == S_EMIT);
      last      <= a_valid && (a_state == S_EMIT) && a_last;
      out_value <= res_word;
      case (state)
        S_IDLE: begin
          if (q_valid && q_head.complete) begin
            dir     <= q_head.dir;
            half    <= q_head.half;
            j       <= '0;
            ph      <= 1'b0;
            pass_no <= 1'b0;
            if (q_head.dir) begin
              state <= S_UPD;
            end else begin
              state <= S_PRED;
            end
          end
        end
        S_PRED, S_UPD, S_EMIT: begin
          ph <= !ph;
          if (ph) begin
            if (j == last_j) begin
              j <= '0;
              if (state == S_EMIT) begin
                state <= S_IDLE;
              end else begin
                state     <= S_DRAIN;
                drain_cnt <= DRAIN_W'(DRAIN_LEN - 1);
              end
            end else begin
              j <= j_inc;
            end
          end
        end
        S_DRAIN: begin
          if (drain_cnt == '0) begin
            if (!pass_no) begin
              pass_no <= 1'b1;
              if (dir) begin
                state <= S_PRED;
              end else begin
                state <= S_UPD;
              end
            end else begin
              state <= S_EMIT;
            end
          end else begin
            drain_cnt <= drain_cnt - DRAIN_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && (a_state == S_PRED) && !a_ph) begin
      e_prev <= dir ? res_word : line_word;
    end
    if (a_valid && (a_state == S_PRED) && a_ph) begin
      o_reg <= line_word;
    end
    if (a_valid && (a_state == S_UPD) && !a_ph) begin
      win[0] <= h_in;
      win[1] <= win[0];
      win[2] <= win[1];
      win[3] <= win[2];
    end
    if (a_valid && (a_state == S_UPD) && a_ph) begin
      u_i  <= a_j_dec;
      u_e  <= $signed(line_rdata);
      u_h0 <= win[1];
      u_s  <= near_sum;
      u_p  <= upd_prod;
    end
  end

endmodule

>>> rtl/core/cdf24_wavelet_lifting_1d_core.sv
`timescale 1ns / 1ps
// Top level of the one-level CDF 2/4 integer lifting wavelet core.
//
// Values are taken one per cycle whenever start is high and busy is low; each
// transfer lands in a four-entry queue, so busy rises only when that queue is
// full. The transform engine drains the queue only while it is idle, moving
// one value per cycle into the line buffer. When the value that completes a
// line of 2*P values (P = pair_count, clamped to 2..32) reaches the engine,
// the engine runs a predict pass and an update pass (in the order the
// direction register selects), with a flush after each, and then an output
// pass that streams the 2*P results, one per cycle, through registers to the
// port. While the passes run, the engine takes no new values from the queue.
// The last result appears in the cycle after the engine returns to idle. The
// pace is set by the single read port of the line buffer and of the result
// buffer, which every pass walks through. Results are shown for exactly one
// cycle with valid high and cannot be held off, so the receiver must take
// every transfer as it comes; last marks the final value of a line.
// Configuration writes are taken at once and belong between lines, when no
// results are outstanding.
module cdf24_wavelet_lifting_1d_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  cdf24wl_pkg::sample_t                 in_value,
  input  logic                                 wr_en,
  input  logic [cdf24wl_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [cdf24wl_pkg::PAIR_W-1:0]       wr_data,
  output logic                                 valid,
  output cdf24wl_pkg::word_t                   out_value,
  output logic                                 last
);
  import cdf24wl_pkg::*;

  logic       queue_full;
  logic       push;
  line_cmd_t  push_cmd;
  logic       q_valid;
  logic       q_pop;
  line_cmd_t  q_head;

  cdf24wl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .in_value   (in_value),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  cdf24wl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  cdf24wl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .valid     (valid),
    .out_value (out_value),
    .last      (last)
  );

endmodule

>>> rtl/core/cdf24wl_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result stream of the wavelet core, bound to the top level.
module cdf24wl_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic valid,
  input logic last
);

  // Reset leaves no transfer on the result port and an empty queue.
  assert property (@(posedge clk) rst |=> (!valid && !busy))
    else $error("result strobe or busy active right after reset");

  // The end-of-line mark only comes with a result transfer.
  assert property (@(posedge clk) disable iff (rst) last |-> valid)
    else $error("last raised without a result transfer");

  // A line is sent as one unbroken burst.
  assert property (@(posedge clk) disable iff (rst) (valid && !last) |=> valid)
    else $error("gap inside a line of results");

  // The next line cannot follow the end of a line immediately.
  assert property (@(posedge clk) disable iff (rst) (valid && last) |=> !valid)
    else $error("result transfer directly after the end of a line");

endmodule

bind cdf24_wavelet_lifting_1d_core cdf24wl_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .valid (valid),
  .last  (last)
);
